>>> sv/dtr_pkg.sv
`default_nettype none
package dtr_pkg;

   localparam int RING_DEPTH = 24;
   localparam int POS_W      = $clog2(RING_DEPTH);
   localparam int CNT_W      = $clog2(RING_DEPTH + 1);
   localparam int ADDR_W     = $clog2(2 * RING_DEPTH);
   localparam int STORE_D    = 2 * RING_DEPTH;
   localparam int IDX_W      = 8;
   localparam int RSUM_W     = ((POS_W > IDX_W) ? POS_W : IDX_W) + 1;
   localparam int SEQ_W      = 32;
   localparam int ID_W       = 16;
   localparam int ENTRY_W    = SEQ_W + 2 * ID_W;

   typedef logic [2:0]         cmd_type;
   typedef logic [ID_W-1:0]    id_type;
   typedef logic [SEQ_W-1:0]   seq_type;
   typedef logic [7:0]         reason_type;
   typedef logic [IDX_W-1:0]   idx_type;
   typedef logic [4:0]         lines_type;
   typedef logic [POS_W-1:0]   pos_type;
   typedef logic [CNT_W-1:0]   cnt_type;
   typedef logic [ADDR_W-1:0]  addr_type;
   typedef logic [RSUM_W-1:0]  rsum_type;
   typedef logic [ENTRY_W-1:0] entry_type;

   localparam cmd_type CMD_RECORD  = 3'd0;
   localparam cmd_type CMD_CLEAR   = 3'd1;
   localparam cmd_type CMD_CAPTURE = 3'd2;
   localparam cmd_type CMD_READ    = 3'd3;
   localparam cmd_type CMD_DROP    = 3'd4;

   // sum of two positions is below twice the depth, one subtract folds it back
   function automatic pos_type wrap_pos(input rsum_type s);
      if (s >= rsum_type'(RING_DEPTH)) begin
         return pos_type'(s - rsum_type'(RING_DEPTH));
      end
      return pos_type'(s);
   endfunction

   function automatic addr_type slot_addr(input logic bank, input pos_type pos);
      if (bank) begin
         return addr_type'(RING_DEPTH) + addr_type'(pos);
      end
      return addr_type'(pos);
   endfunction

endpackage
`default_nettype wire

>>> sv/dtr_ram.sv
`default_nettype none
module dtr_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 48
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read data holds until the next enabled read
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wr_data;
         end else begin
            rd_data_ff <= mem_ff[addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> sv/dedup_event_trace_ring_unit.sv
// Event trace ring with dedup of repeated events and crash-report capture.
// Request channel (req_*): one command beat with its operands; valid/ready.
// Response channel (rsp_*): exactly one beat per request, in order.
// Commands: record an event, clear the live log, capture a non-empty live
// log as a report if crash-like, read one report line (0 is the header),
// drop the report. For each command the accept edge issues a read of the
// single-port entry store (newest live entry or report entry); the edge
// that leaves the execute state uses the read data, writes the store back
// for a record and loads the response register, which raises rsp_valid.
// One item is in flight at a time: a new request is not taken until the
// current one has left the execute state.
// The response register holds a finished beat while the next request is
// taken; if the receiver stalls, the following item waits in the execute
// state until the response register frees up, and req_ready stays low.
// Reset (synchronous, active high) empties the live log and the report and
// sets the sequence number to 1; the entry store is not cleared, since no
// command reads an entry that was never written.
`default_nettype none
module dedup_event_trace_ring_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  dtr_pkg::cmd_type       req_cmd,
   input  dtr_pkg::id_type        req_event_id,
   input  dtr_pkg::id_type        req_event_arg,
   input  logic                   req_crash_like,
   input  dtr_pkg::reason_type    req_reset_reason,
   input  dtr_pkg::idx_type       req_read_index,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_ok,
   output dtr_pkg::lines_type     rsp_report_lines,
   output dtr_pkg::lines_type     rsp_report_count,
   output dtr_pkg::reason_type    rsp_report_reason,
   output logic                   rsp_is_header,
   output dtr_pkg::seq_type       rsp_entry_seq,
   output dtr_pkg::id_type        rsp_entry_id,
   output dtr_pkg::id_type        rsp_entry_arg
);

   import dtr_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic       state_ff, state_in;
   cmd_type    cmd_ff;
   id_type     id_ff, arg_ff;
   logic       crash_ff;
   reason_type reason_ff;
   idx_type    idx_ff;

   logic       live_bank_ff, live_bank_in;
   pos_type    live_head_ff, live_head_in;
   cnt_type    live_count_ff, live_count_in;
   seq_type    next_seq_ff, next_seq_in;
   pos_type    rpt_head_ff, rpt_head_in;
   cnt_type    rpt_entries_ff, rpt_entries_in;
   logic       rpt_valid_ff, rpt_valid_in;
   reason_type rpt_reason_ff, rpt_reason_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_ok_ff, rsp_ok_in;
   lines_type  rsp_lines_ff, rsp_lines_in;
   lines_type  rsp_count_ff, rsp_count_in;
   reason_type rsp_reason_ff, rsp_reason_in;
   logic       rsp_hdr_ff, rsp_hdr_in;
   seq_type    rsp_seq_ff, rsp_seq_in;
   id_type     rsp_id_ff, rsp_id_in;
   id_type     rsp_arg_ff, rsp_arg_in;

   logic       accept;
   logic       out_free;
   logic       exec_go;
   logic       live_nonempty;
   pos_type    newest_pos;
   addr_type   newest_addr;
   logic       req_hit;
   logic       exec_hit;
   pos_type    req_rpt_pos;
   pos_type    append_pos;
   logic       dedup;
   entry_type  ram_rd;
   entry_type  ram_wr;
   addr_type   ram_addr;
   logic       ram_en;
   logic       ram_we;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign exec_go  = (state_ff == ST_EXEC) && out_free;
   assign req_ready = (state_ff == ST_IDLE);

   // newest live entry
   assign live_nonempty = (live_count_ff != '0);
   assign newest_pos = live_nonempty ?
      wrap_pos(rsum_type'(live_head_ff) + rsum_type'(live_count_ff) - rsum_type'(1)) : '0;
   assign newest_addr = slot_addr(live_bank_ff, newest_pos);

   // report entry lines are 1..count
   assign req_hit = rpt_valid_ff && (req_read_index != '0) &&
                    (rsum_type'(req_read_index) <= rsum_type'(rpt_entries_ff));
   assign exec_hit = rpt_valid_ff && (idx_ff != '0) &&
                     (rsum_type'(idx_ff) <= rsum_type'(rpt_entries_ff));
   assign req_rpt_pos = req_hit ?
      wrap_pos(rsum_type'(rpt_head_ff) + rsum_type'(req_read_index) - rsum_type'(1)) : '0;

   assign append_pos = (live_count_ff < cnt_type'(RING_DEPTH)) ?
      wrap_pos(rsum_type'(live_head_ff) + rsum_type'(live_count_ff)) : live_head_ff;

   assign dedup = live_nonempty && (ram_rd[2*ID_W-1:ID_W] == id_ff) &&
                  (ram_rd[ID_W-1:0] == arg_ff);

   always_comb begin
      ram_en   = 1'b0;
      ram_we   = 1'b0;
      ram_addr = newest_addr;
      ram_wr   = {next_seq_ff, id_ff, arg_ff};
      if (state_ff == ST_IDLE) begin
         ram_en = accept;
         if (req_cmd == CMD_READ) begin
            ram_addr = slot_addr(!live_bank_ff, req_rpt_pos);
         end
      end else begin
         ram_we = exec_go && (cmd_ff == CMD_RECORD);
         ram_en = ram_we;
         if (dedup) begin
            ram_wr = {next_seq_ff, ram_rd[2*ID_W-1:0]};
         end else begin
            ram_addr = slot_addr(live_bank_ff, append_pos);
         end
      end
   end

   dtr_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (STORE_D)
   ) u_store (
      .clock   (clock),
      .en      (ram_en),
      .we      (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wr),
      .rd_data (ram_rd)
   );

   always_comb begin
      state_in       = state_ff;
      live_bank_in   = live_bank_ff;
      live_head_in   = live_head_ff;
      live_count_in  = live_count_ff;
      next_seq_in    = next_seq_ff;
      rpt_head_in    = rpt_head_ff;
      rpt_entries_in = rpt_entries_ff;
      rpt_valid_in   = rpt_valid_ff;
      rpt_reason_in  = rpt_reason_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_ok_in      = rsp_ok_ff;
      rsp_hdr_in     = rsp_hdr_ff;
      rsp_seq_in     = rsp_seq_ff;
      rsp_id_in      = rsp_id_ff;
      rsp_arg_in     = rsp_arg_ff;
      rsp_lines_in   = rsp_lines_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_reason_in  = rsp_reason_ff;

      if (accept) begin
         state_in = ST_EXEC;
      end

      if (exec_go) begin
         state_in     = ST_IDLE;
         rsp_valid_in = 1'b1;
         rsp_ok_in    = 1'b0;
         rsp_hdr_in   = 1'b0;
         rsp_seq_in   = '0;
         rsp_id_in    = '0;
         rsp_arg_in   = '0;
         case (cmd_ff)
            CMD_RECORD: begin
               rsp_ok_in   = 1'b1;
               next_seq_in = next_seq_ff + seq_type'(1);
               if (!dedup) begin
                  if (live_count_ff < cnt_type'(RING_DEPTH)) begin
                     live_count_in = live_count_ff + cnt_type'(1);
                  end else if (live_head_ff == pos_type'(RING_DEPTH - 1)) begin
                     live_head_in = '0;
                  end else begin
                     live_head_in = live_head_ff + pos_type'(1);
                  end
               end
            end
            CMD_CLEAR: begin
               rsp_ok_in     = 1'b1;
               live_head_in  = '0;
               live_count_in = '0;
               next_seq_in   = seq_type'(1);
            end
            CMD_CAPTURE: begin
               if (crash_ff && live_nonempty) begin
                  rsp_ok_in      = 1'b1;
                  rpt_head_in    = live_head_ff;
                  rpt_entries_in = live_count_ff;
                  rpt_valid_in   = 1'b1;
                  rpt_reason_in  = reason_ff;
                  live_bank_in   = !live_bank_ff;
                  live_head_in   = '0;
                  live_count_in  = '0;
                  next_seq_in    = seq_type'(1);
               end
            end
            CMD_READ: begin
               if (rpt_valid_ff && (idx_ff == '0)) begin
                  rsp_ok_in  = 1'b1;
                  rsp_hdr_in = 1'b1;
               end else if (exec_hit) begin
                  rsp_ok_in  = 1'b1;
                  rsp_seq_in = ram_rd[ENTRY_W-1:2*ID_W];
                  rsp_id_in  = ram_rd[2*ID_W-1:ID_W];
                  rsp_arg_in = ram_rd[ID_W-1:0];
               end
            end
            CMD_DROP: begin
               rsp_ok_in      = 1'b1;
               rpt_valid_in   = 1'b0;
               rpt_entries_in = '0;
               rpt_head_in    = '0;
               rpt_reason_in  = '0;
            end
            default: begin
               rsp_ok_in = 1'b0;
            end
         endcase
         // report summary shows the state after the command
         rsp_lines_in  = rpt_valid_in ? lines_type'(rpt_entries_in + cnt_type'(1)) : '0;
         rsp_count_in  = rpt_valid_in ? lines_type'(rpt_entries_in) : '0;
         rsp_reason_in = rpt_valid_in ? rpt_reason_in : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         live_bank_ff   <= 1'b0;
         live_head_ff   <= '0;
         live_count_ff  <= '0;
         next_seq_ff    <= seq_type'(1);
         rpt_head_ff    <= '0;
         rpt_entries_ff <= '0;
         rpt_valid_ff   <= 1'b0;
         rpt_reason_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         live_bank_ff   <= live_bank_in;
         live_head_ff   <= live_head_in;
         live_count_ff  <= live_count_in;
         next_seq_ff    <= next_seq_in;
         rpt_head_ff    <= rpt_head_in;
         rpt_entries_ff <= rpt_entries_in;
         rpt_valid_ff   <= rpt_valid_in;
         rpt_reason_ff  <= rpt_reason_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff    <= req_cmd;
         id_ff     <= req_event_id;
         arg_ff    <= req_event_arg;
         crash_ff  <= req_crash_like;
         reason_ff <= req_reset_reason;
         idx_ff    <= req_read_index;
      end
      rsp_ok_ff     <= rsp_ok_in;
      rsp_hdr_ff    <= rsp_hdr_in;
      rsp_seq_ff    <= rsp_seq_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_arg_ff    <= rsp_arg_in;
      rsp_lines_ff  <= rsp_lines_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_reason_ff <= rsp_reason_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ok            = rsp_ok_ff;
   assign rsp_report_lines  = rsp_lines_ff;
   assign rsp_report_count  = rsp_count_ff;
   assign rsp_report_reason = rsp_reason_ff;
   assign rsp_is_header     = rsp_hdr_ff;
   assign rsp_entry_seq     = rsp_seq_ff;
   assign rsp_entry_id      = rsp_id_ff;
   assign rsp_entry_arg     = rsp_arg_ff;

endmodule
`default_nettype wire

>>> sv/dtr_checker.sv
`default_nettype none
module dtr_checker (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire dtr_pkg::cmd_type    req_cmd,
   input wire dtr_pkg::id_type     req_event_id,
   input wire dtr_pkg::id_type     req_event_arg,
   input wire logic                req_crash_like,
   input wire dtr_pkg::reason_type req_reset_reason,
   input wire dtr_pkg::idx_type    req_read_index,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic                rsp_ok,
   input wire dtr_pkg::lines_type  rsp_report_lines,
   input wire dtr_pkg::lines_type  rsp_report_count,
   input wire dtr_pkg::reason_type rsp_report_reason,
   input wire logic                rsp_is_header,
   input wire dtr_pkg::seq_type    rsp_entry_seq,
   input wire dtr_pkg::id_type     rsp_entry_id,
   input wire dtr_pkg::id_type     rsp_entry_arg
);

   import dtr_pkg::*;

   logic unused_ok;
   assign unused_ok = ^{req_cmd, req_event_id, req_event_arg, req_crash_like,
                        req_reset_reason, req_read_index, rsp_entry_id, rsp_entry_arg};

   // one command in flight: no second accept right after the first
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous command still executing");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_entry_seq) && $stable(rsp_ok))
      else $error("stalled response beat changed");

   a_lines_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_report_lines != '0) |->
         rsp_report_lines == lines_type'(rsp_report_count + lines_type'(1)))
      else $error("report lines not count plus one");

   a_no_report: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_report_lines == '0) |->
         (rsp_report_count == '0) && (rsp_report_reason == '0))
      else $error("report fields set without a report");

   a_header: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_header |-> rsp_ok && (rsp_entry_seq == '0) &&
         (rsp_report_lines != '0))
      else $error("header beat without a valid report");

endmodule

bind dedup_event_trace_ring_unit dtr_checker u_dtr_checker (.*);
`default_nettype wire
